[rtl/mtsg_pkg.sv]
// shared types, constants and sine table function for the multi-tone sine generator
package mtsg_pkg;

  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int TONE_COUNT_W   = 3;
  localparam int FULL_SCALE_W   = 31;
  localparam int SAMPLE_COUNT_W = 24;
  localparam int PHASE_INC_W    = 32;
  localparam int PHASE_INC_REGS = 4;
  localparam int SAMPLE_W       = 32;
  localparam int SINE_W         = 15;

  localparam logic [CFG_IDX_W-1:0] REG_TONE_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC_0  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC_1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC_2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC_3  = 3'd6;

  localparam logic [TONE_COUNT_W-1:0]   TONE_COUNT_RST   = 3'd1;
  localparam logic [FULL_SCALE_W-1:0]   FULL_SCALE_RST   = 31'd32767;
  localparam logic [SAMPLE_COUNT_W-1:0] SAMPLE_COUNT_RST = 24'd1024;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SINE_MAX    = 64'd32767;

  typedef struct packed {
    logic start;
    logic tone_en;
    logic mul_en;
    logic div_start;
    logic load_out;
  } mtsg_cmd_t;

  typedef struct packed {
    logic tone_last;
    logic multi;
    logic div_done;
  } mtsg_sts_t;

  // q0.15 sine of k quarter-wave steps, odd taylor series in q30
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
                                                     input int unsigned abits);
    longint unsigned k64;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned r;
    k64 = longint'(k);
    x   = (k64 * HALF_PI_Q30) >> abits;
    x2  = (x * x) >> 30;
    t   = Q30_ONE;
    t   = Q30_ONE - (((x2 * t) >> 30) / 110);
    t   = Q30_ONE - (((x2 * t) >> 30) / 72);
    t   = Q30_ONE - (((x2 * t) >> 30) / 42);
    t   = Q30_ONE - (((x2 * t) >> 30) / 20);
    t   = Q30_ONE - (((x2 * t) >> 30) / 6);
    r   = (x * t) >> 30;
    r   = (r + 64'd16384) >> 15;
    if (r > SINE_MAX) begin
      r = SINE_MAX;
    end
    return r[SINE_W-1:0];
  endfunction

endpackage

[rtl/mtsg_if.sv]
// item channels of the multi-tone sine generator
interface mtsg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface mtsg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mtsg_pkg::SAMPLE_W-1:0] sample;
  logic                                 last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

[rtl/mtsg_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
module mtsg_div #(
  parameter int DIVD_W = 35,
  parameter int DIVS_W = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic [DIVD_W-1:0] quot,
  output logic              done
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] q_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] div_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;
  logic [DIVS_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, q_r[DIVD_W-1]};
    diff    = trial - {1'b0, div_r};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DIVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quot = q_r;
  assign done = done_r;

  a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider not busy after start");

  a_rem_below : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < div_r))
    else $error("partial remainder not below divisor");

  a_done_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r))
    else $error("divider done without running");

endmodule

[rtl/mtsg_dpath.sv]
// datapath: configuration, phase accumulators, sine table, sum, scaling, divider and result register
module mtsg_dpath #(
  parameter int MAX_TONES            = 4,
  parameter int PHASE_BITS           = 32,
  parameter int SINE_TABLE_ADDR_BITS = 10
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [mtsg_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [mtsg_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    in_restart,
  input  mtsg_pkg::mtsg_cmd_t                     cmd,
  output mtsg_pkg::mtsg_sts_t                     sts,
  output logic signed [mtsg_pkg::SAMPLE_W-1:0]    out_sample,
  output logic                                    out_last
);

  localparam int TBL_LEN = 1 << SINE_TABLE_ADDR_BITS;
  localparam int ROM_AW  = SINE_TABLE_ADDR_BITS + 1;
  localparam int IDX_W   = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int N_W     = $clog2(MAX_TONES + 1);
  localparam int ACC_W   = 17 + $clog2(MAX_TONES + 1);
  localparam int PROD_W  = ACC_W + mtsg_pkg::FULL_SCALE_W;
  localparam int DIVD_W  = PROD_W - 16;
  localparam int SW      = mtsg_pkg::SINE_W;

  logic [mtsg_pkg::TONE_COUNT_W-1:0]   tone_count_r;
  logic [mtsg_pkg::FULL_SCALE_W-1:0]   full_scale_r;
  logic [mtsg_pkg::SAMPLE_COUNT_W-1:0] sample_count_r;
  logic [mtsg_pkg::PHASE_INC_W-1:0]    phase_inc_r [mtsg_pkg::PHASE_INC_REGS];

  logic [PHASE_BITS-1:0] phase_r   [MAX_TONES];
  logic [PHASE_BITS-1:0] phase_nxt [MAX_TONES];
  logic [IDX_W-1:0]      tone_idx_r;

  logic [mtsg_pkg::SAMPLE_COUNT_W-1:0] sample_idx_r;
  logic [mtsg_pkg::SAMPLE_COUNT_W-1:0] idx_eff;
  logic                                last_hit;
  logic                                last_pend_r;

  logic [SW-1:0]  sine_rom [TBL_LEN+1];
  logic [SW-1:0]  rom_q_r;
  logic           neg_r;
  logic           use_r;
  logic           vld_r;

  logic signed [ACC_W-1:0]  acc_r;
  logic [PROD_W-1:0]        prod_r;
  logic                     res_neg_r;
  logic [DIVD_W-1:0]        quot;
  logic                     div_done;

  logic [N_W-1:0]            n_eff;
  logic                      multi;
  logic                      use_tone;
  logic [PHASE_BITS-1:0]     phase_rd;
  logic [1:0]                quad;
  logic [SINE_TABLE_ADDR_BITS-1:0] k_sel;
  logic [ROM_AW-1:0]         rom_addr;
  logic [1:0]                inc_idx;
  logic [mtsg_pkg::PHASE_INC_W-1:0] inc_word;
  logic [63:0]               inc_ext;
  logic [PHASE_BITS-1:0]     inc_sel;
  logic signed [ACC_W-1:0]   sine_ext;
  logic signed [ACC_W-1:0]   n_off;
  logic signed [ACC_W-1:0]   op_signed;
  logic [ACC_W-1:0]          op;
  logic [mtsg_pkg::FULL_SCALE_W-1:0] mag;
  logic [mtsg_pkg::SAMPLE_W-1:0]     single_res;

  for (genvar k = 0; k <= TBL_LEN; k++) begin : g_rom
    assign sine_rom[k] = mtsg_pkg::quarter_sine(k, SINE_TABLE_ADDR_BITS);
  end

  always_comb begin
    n_eff    = (32'(tone_count_r) > MAX_TONES) ? N_W'(MAX_TONES) : N_W'(tone_count_r);
    multi    = n_eff > N_W'(1);
    use_tone = 32'(tone_idx_r) < 32'(n_eff);
    phase_rd = phase_r[tone_idx_r];
    quad     = phase_rd[PHASE_BITS-1 -: 2];
    k_sel    = phase_rd[PHASE_BITS-3 -: SINE_TABLE_ADDR_BITS];
    rom_addr = quad[0] ? (ROM_AW'(TBL_LEN) - {1'b0, k_sel}) : {1'b0, k_sel};
    inc_idx  = 2'(tone_idx_r);
    inc_word = (32'(tone_idx_r) < mtsg_pkg::PHASE_INC_REGS) ? phase_inc_r[inc_idx] : '0;
    inc_ext  = {32'd0, inc_word};
    inc_sel  = inc_ext[PHASE_BITS-1:0];
    idx_eff  = in_restart ? '0 : sample_idx_r;
    last_hit = idx_eff == (sample_count_r - 1'b1);
    sine_ext = $signed({{(ACC_W-SW){1'b0}}, rom_q_r});
    n_off    = $signed(ACC_W'(n_eff) << 15);
    if (multi) begin
      op_signed = acc_r + n_off;
    end else if (acc_r < 0) begin
      op_signed = -acc_r;
    end else begin
      op_signed = acc_r;
    end
    op         = op_signed;
    mag        = prod_r[15 +: mtsg_pkg::FULL_SCALE_W];
    single_res = res_neg_r ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
  end

  always_comb begin
    phase_nxt = phase_r;
    if (cmd.start && in_restart) begin
      for (int i = 0; i < MAX_TONES; i++) begin
        phase_nxt[i] = '0;
      end
    end else if (cmd.tone_en) begin
      phase_nxt[tone_idx_r] = phase_rd + inc_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_count_r   <= mtsg_pkg::TONE_COUNT_RST;
      full_scale_r   <= mtsg_pkg::FULL_SCALE_RST;
      sample_count_r <= mtsg_pkg::SAMPLE_COUNT_RST;
      for (int i = 0; i < mtsg_pkg::PHASE_INC_REGS; i++) begin
        phase_inc_r[i] <= '0;
      end
      for (int i = 0; i < MAX_TONES; i++) begin
        phase_r[i] <= '0;
      end
      sample_idx_r <= '0;
      tone_idx_r   <= '0;
      vld_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          mtsg_pkg::REG_TONE_COUNT:   tone_count_r   <= cfg_data[mtsg_pkg::TONE_COUNT_W-1:0];
          mtsg_pkg::REG_FULL_SCALE:   full_scale_r   <= cfg_data[mtsg_pkg::FULL_SCALE_W-1:0];
          mtsg_pkg::REG_SAMPLE_COUNT: sample_count_r <= cfg_data[mtsg_pkg::SAMPLE_COUNT_W-1:0];
          mtsg_pkg::REG_PHASE_INC_0:  phase_inc_r[0] <= cfg_data;
          mtsg_pkg::REG_PHASE_INC_1:  phase_inc_r[1] <= cfg_data;
          mtsg_pkg::REG_PHASE_INC_2:  phase_inc_r[2] <= cfg_data;
          mtsg_pkg::REG_PHASE_INC_3:  phase_inc_r[3] <= cfg_data;
          default: begin
          end
        endcase
      end
      phase_r <= phase_nxt;
      if (cmd.start) begin
        sample_idx_r <= last_hit ? '0 : idx_eff + 1'b1;
        tone_idx_r   <= '0;
      end else if (cmd.tone_en && !sts.tone_last) begin
        tone_idx_r <= tone_idx_r + 1'b1;
      end
      vld_r <= cmd.tone_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      last_pend_r <= last_hit;
    end
    if (cmd.tone_en) begin
      rom_q_r <= sine_rom[rom_addr];
      neg_r   <= quad[1];
      use_r   <= use_tone;
    end
    if (cmd.start) begin
      acc_r <= '0;
    end else if (vld_r && use_r) begin
      acc_r <= neg_r ? (acc_r - sine_ext) : (acc_r + sine_ext);
    end
    if (cmd.mul_en) begin
      prod_r    <= op * full_scale_r;
      res_neg_r <= !multi && (acc_r < 0);
    end
    if (cmd.load_out) begin
      out_sample <= multi ? $signed(quot[mtsg_pkg::SAMPLE_W-1:0]) : $signed(single_res);
      out_last   <= last_pend_r;
    end
  end

  mtsg_div #(
    .DIVD_W (DIVD_W),
    .DIVS_W (N_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r[PROD_W-1:16]),
    .divisor  (n_eff),
    .quot     (quot),
    .done     (div_done)
  );

  assign sts.tone_last = tone_idx_r == IDX_W'(MAX_TONES - 1);
  assign sts.multi     = multi;
  assign sts.div_done  = div_done;

endmodule

[rtl/mtsg_ctrl.sv]
// controller state machine sequencing tone loop, scaling, divide and result hand-off
module mtsg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output mtsg_pkg::mtsg_cmd_t cmd,
  input  mtsg_pkg::mtsg_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.tone_en = 1'b1;
        if (sts.tone_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = sts.multi ? ST_DIV_GO : ST_DONE;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;

  a_accept_sum : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SUM))
    else $error("accepted item did not start the tone loop");

  a_valid_from_done : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result shown without finishing an item");

  a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("waiting item dropped");

endmodule

[rtl/multi_tone_sine_generator.sv]
// multi-tone sine generator top level
// per accepted item: the tone loop over all MAX_TONES slots, a drain state, the scaling
// multiply, with several tones a bit-serial divide of the 35-bit scaled sum by the tone
// count (default widths), then the result register load, which waits while a result is
// unaccepted; the next item is taken once the result is loaded, while that result waits
// reset: synchronous active-low, loads register defaults, zeroes phases and sample index
module multi_tone_sine_generator #(
  parameter int MAX_TONES            = 4,
  parameter int PHASE_BITS           = 32,
  parameter int SINE_TABLE_ADDR_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mtsg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [mtsg_pkg::CFG_DATA_W-1:0] cfg_data,
  mtsg_in_if.sink                         in_ch,
  mtsg_out_if.source                      out_ch
);

  mtsg_pkg::mtsg_cmd_t cmd;
  mtsg_pkg::mtsg_sts_t sts;

  mtsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mtsg_dpath #(
    .MAX_TONES            (MAX_TONES),
    .PHASE_BITS           (PHASE_BITS),
    .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_restart (in_ch.restart),
    .cmd        (cmd),
    .sts        (sts),
    .out_sample (out_ch.sample),
    .out_last   (out_ch.last)
  );

endmodule

[verif/tb_top.sv]
// self-checking testbench for the multi-tone sine generator: directed table then random phases
`timescale 1ns / 100ps

module tb_top;

  localparam int TONES          = 4;
  localparam int TBL_BITS       = 10;
  localparam int TBL_LEN        = 1 << TBL_BITS;
  localparam int RANDOM_ITEMS   = 450;
  localparam int SETTLE_CYCLES  = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [mtsg_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    logic signed [mtsg_pkg::SAMPLE_W-1:0] sample;
    logic                                 last;
  } dds_sample_t;

  typedef enum bit {STEP_WRITE, STEP_ITEM} dir_kind_t;

  typedef struct {
    dir_kind_t                       kind;
    logic [mtsg_pkg::CFG_IDX_W-1:0]  idx;
    logic [mtsg_pkg::CFG_DATA_W-1:0] data;
    logic                            restart;
    bit                              known;
    dds_sample_t                     want;
  } dir_step_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [mtsg_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [mtsg_pkg::CFG_DATA_W-1:0] cfg_data;

  mtsg_in_if  in_ch();
  mtsg_out_if out_ch();

  multi_tone_sine_generator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // predictor state
  int                                  sine_q15 [0:TBL_LEN];
  logic [mtsg_pkg::TONE_COUNT_W-1:0]   tones_r;
  logic [mtsg_pkg::FULL_SCALE_W-1:0]   scale_r;
  logic [mtsg_pkg::SAMPLE_COUNT_W-1:0] run_len_r;
  logic [mtsg_pkg::PHASE_INC_W-1:0]    step_r [TONES];
  logic [mtsg_pkg::PHASE_INC_W-1:0]    phase_acc [TONES];
  logic [mtsg_pkg::SAMPLE_COUNT_W-1:0] sample_idx;

  dds_sample_t expected_samples [$];
  dir_step_t   directed_steps [$];

  int  fails = 0;
  int  items_sent;
  int  random_items;
  int  settings_used;
  int  writes_done;
  int  results_seen = 0;
  int  lasts_seen = 0;
  int  quiet_cycles = 0;
  int  burst_left;
  bit  gapless;
  bit  offering;
  bit  cfg_open;
  bit  hold_req;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;
  logic [8:0] stall_phase;

  function automatic void build_sine_table();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned r;
    longint unsigned taylor_div [5];
    taylor_div = '{110, 72, 42, 20, 6};
    for (int k = 0; k <= TBL_LEN; k++) begin
      x  = 64'(k);
      x  = (x * mtsg_pkg::HALF_PI_Q30) >> TBL_BITS;
      x2 = (x * x) >> 30;
      t  = mtsg_pkg::Q30_ONE;
      foreach (taylor_div[d]) t = mtsg_pkg::Q30_ONE - (((x2 * t) >> 30) / taylor_div[d]);
      r = (x * t) >> 30;
      r = (r + 16384) >> 15;
      if (r > 32767) r = 32767;
      sine_q15[k] = int'(r);
    end
  endfunction

  function automatic int tone_sine(input logic [mtsg_pkg::PHASE_INC_W-1:0] p);
    int mag;
    mag = p[30] ? sine_q15[TBL_LEN - p[29:20]] : sine_q15[p[29:20]];
    return p[31] ? -mag : mag;
  endfunction

  function automatic void reset_model();
    tones_r    = mtsg_pkg::TONE_COUNT_RST;
    scale_r    = mtsg_pkg::FULL_SCALE_RST;
    run_len_r  = mtsg_pkg::SAMPLE_COUNT_RST;
    sample_idx = '0;
    for (int i = 0; i < TONES; i++) begin
      step_r[i]    = '0;
      phase_acc[i] = '0;
    end
  endfunction

  function automatic void apply_reg(input logic [mtsg_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [mtsg_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      mtsg_pkg::REG_TONE_COUNT:   tones_r = data[mtsg_pkg::TONE_COUNT_W-1:0];
      mtsg_pkg::REG_FULL_SCALE:   scale_r = data[mtsg_pkg::FULL_SCALE_W-1:0];
      mtsg_pkg::REG_SAMPLE_COUNT: run_len_r = data[mtsg_pkg::SAMPLE_COUNT_W-1:0];
      mtsg_pkg::REG_PHASE_INC_0:  step_r[0] = data;
      mtsg_pkg::REG_PHASE_INC_1:  step_r[1] = data;
      mtsg_pkg::REG_PHASE_INC_2:  step_r[2] = data;
      mtsg_pkg::REG_PHASE_INC_3:  step_r[3] = data;
      default: ;
    endcase
  endfunction

  function automatic dds_sample_t next_sample(input logic restart);
    dds_sample_t     r;
    int              n;
    longint          acc;
    longint unsigned scale;
    longint unsigned mag;
    n = (tones_r > TONES) ? TONES : int'(tones_r);
    if (restart) begin
      for (int i = 0; i < TONES; i++) phase_acc[i] = '0;
      sample_idx = '0;
    end
    acc = 0;
    for (int i = 0; i < n; i++) acc += longint'(tone_sine(phase_acc[i]));
    scale = 64'(scale_r);
    if (n > 1) begin
      // biased sum over twice the tone count, never negative
      mag = acc + longint'(n) * 32768;
      mag = (mag * scale) / (longint'(n) * 65536);
      r.sample = mag[31:0];
    end else if (acc < 0) begin
      mag = -acc;
      mag = (mag * scale) >> 15;
      r.sample = 32'd0 - mag[31:0];
    end else begin
      mag = acc;
      mag = (mag * scale) >> 15;
      r.sample = mag[31:0];
    end
    for (int i = 0; i < TONES; i++) phase_acc[i] = phase_acc[i] + step_r[i];
    r.last = (sample_idx == run_len_r - 24'd1);
    sample_idx = r.last ? '0 : sample_idx + 24'd1;
    return r;
  endfunction

  function automatic void dir_write(input logic [mtsg_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [mtsg_pkg::CFG_DATA_W-1:0] data);
    dir_step_t s;
    s.kind    = STEP_WRITE;
    s.idx     = idx;
    s.data    = data;
    s.restart = 1'b0;
    s.known   = 1'b0;
    s.want    = '{0, 1'b0};
    directed_steps.push_back(s);
  endfunction

  function automatic void dir_item(input logic restart, input bit known,
                                   input int sample, input logic last);
    dir_step_t s;
    s.kind    = STEP_ITEM;
    s.idx     = '0;
    s.data    = '0;
    s.restart = restart;
    s.known   = known;
    s.want    = '{sample, last};
    directed_steps.push_back(s);
  endfunction

  task automatic write_reg(input logic [mtsg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mtsg_pkg::CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_open = 1'b1;
    writes_done++;
  endtask

  task automatic send_item(input logic restart, input bit known, input dds_sample_t want);
    dds_sample_t got;
    if (cfg_open) begin
      cfg_we <= 1'b0;
      cfg_open = 1'b0;
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = next_sample(restart);
    expected_samples.push_back(known ? want : got);
    items_sent++;
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid   <= 1'b0;
        in_ch.restart <= 1'($urandom_range(0, 1));
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 10);
    end
  endtask

  // stop offering and let every pending sample come out
  task automatic drain();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: own stall pattern, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_phase  <= '0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 9'd1;
      case (stall_phase[8:7])
        2'd0: out_ch.ready <= 1'b1;
        2'd1: out_ch.ready <= 1'($urandom_range(0, 1));
        2'd2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (stall_phase[2:0] != 3'd0);
      endcase
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    dds_sample_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.last) lasts_seen++;
        if (expected_samples.size() == 0) begin
          $error("unexpected sample %0d with last %0b", out_ch.sample, out_ch.last);
          fails++;
        end else begin
          want = expected_samples.pop_front();
          if (out_ch.sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, out_ch.sample);
            fails++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            fails++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL multi_tone_sine_generator");
        $finish;
      end
    end
  end

  initial begin
    logic [mtsg_pkg::CFG_DATA_W-1:0] val;
    logic                            restart;
    int                              n_items;
    int                              phase_no;
    dds_sample_t                     none;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.restart <= 1'b0;
    items_sent = 0;
    random_items = 0;
    settings_used = 1;
    writes_done = 0;
    burst_left = 0;
    gapless = 1'b0;
    offering = 1'b0;
    cfg_open = 1'b0;
    hold_req = 1'b0;
    none = '{0, 1'b0};
    build_sine_table();
    reset_model();

    // reset defaults, then quarter-cycle steps over a three-sample run
    dir_item(1'b0, 1'b1, 0, 1'b0);
    dir_item(1'b1, 1'b1, 0, 1'b0);
    dir_write(mtsg_pkg::REG_SAMPLE_COUNT, 32'd3);
    dir_write(mtsg_pkg::REG_PHASE_INC_0, 32'h4000_0000);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    // no active tones
    dir_write(mtsg_pkg::REG_TONE_COUNT, 32'd0);
    dir_item(1'b1, 1'b1, 0, 1'b0);
    // all tones at full scale, extreme steps
    dir_write(mtsg_pkg::REG_TONE_COUNT, 32'd4);
    dir_write(mtsg_pkg::REG_FULL_SCALE, 32'hFFFF_FFFF);
    dir_write(mtsg_pkg::REG_PHASE_INC_1, 32'hFFFF_FFFF);
    dir_write(mtsg_pkg::REG_PHASE_INC_2, 32'h8000_0000);
    dir_write(mtsg_pkg::REG_PHASE_INC_3, 32'h1234_5678);
    dir_item(1'b1, 1'b1, 1073741823, 1'b0);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    // tone count above the maximum
    dir_write(mtsg_pkg::REG_TONE_COUNT, 32'hFFFF_FFFF);
    dir_item(1'b1, 1'b1, 1073741823, 1'b0);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    // single tone, smallest scale: values of either sign truncate to zero
    dir_write(mtsg_pkg::REG_TONE_COUNT, 32'd1);
    dir_write(mtsg_pkg::REG_FULL_SCALE, 32'd1);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    // one-sample runs
    dir_write(mtsg_pkg::REG_SAMPLE_COUNT, 32'd1);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    // zero sample count and a write to an unused index
    dir_write(mtsg_pkg::REG_SAMPLE_COUNT, 32'd0);
    dir_write(REG_SPARE, 32'hFFFF_FFFF);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    // run length lowered below the current index
    dir_write(mtsg_pkg::REG_SAMPLE_COUNT, 32'd1024);
    dir_write(mtsg_pkg::REG_FULL_SCALE, 32'd32767);
    dir_item(1'b1, 1'b0, 0, 1'b0);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    dir_write(mtsg_pkg::REG_SAMPLE_COUNT, 32'd2);
    dir_item(1'b0, 1'b0, 0, 1'b0);
    dir_item(1'b0, 1'b0, 0, 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_WRITE) begin
        if (!cfg_open) begin
          drain();
          settings_used++;
        end
        write_reg(directed_steps[i].idx, directed_steps[i].data);
      end else begin
        send_item(directed_steps[i].restart, directed_steps[i].known, directed_steps[i].want);
        pace();
      end
    end

    phase_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      drain();
      settings_used++;
      val = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 7);
      write_reg(mtsg_pkg::REG_TONE_COUNT, val);
      case ($urandom_range(0, 3))
        0: val = 32'd1;
        1: val = 32'h7FFF_FFFF;
        2: val = $urandom_range(1, 65535);
        default: val = $urandom_range(1, 32'h7FFF_FFFF);
      endcase
      write_reg(mtsg_pkg::REG_FULL_SCALE, val);
      case ($urandom_range(0, 7))
        0: val = 32'hFF_FFFF;
        1: val = $urandom_range(1, 32'hFF_FFFF);
        default: val = $urandom_range(1, 24);
      endcase
      write_reg(mtsg_pkg::REG_SAMPLE_COUNT, val);
      for (int t = 0; t < TONES; t++) begin
        case ($urandom_range(0, 3))
          0: val = 32'd0;
          1: val = $urandom_range(1, 32'h0100_0000);
          default: val = $urandom;
        endcase
        case (t)
          0: write_reg(mtsg_pkg::REG_PHASE_INC_0, val);
          1: write_reg(mtsg_pkg::REG_PHASE_INC_1, val);
          2: write_reg(mtsg_pkg::REG_PHASE_INC_2, val);
          default: write_reg(mtsg_pkg::REG_PHASE_INC_3, val);
        endcase
      end
      if (phase_no % 4 == 2) write_reg(REG_SPARE, $urandom);
      gapless = (phase_no % 3 == 1);
      if (phase_no == 1) hold_req = 1'b1;
      n_items = $urandom_range(30, 70);
      for (int j = 0; j < n_items; j++) begin
        restart = (j == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
        send_item(restart, 1'b0, none);
        random_items++;
        pace();
        // sender waits for every pending sample once mid-phase
        if (phase_no == 3 && j == n_items / 2) drain();
      end
      phase_no++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $error("%0d samples never arrived", expected_samples.size());
    end
    $display("covered %0d items (%0d random) over %0d settings with %0d register writes",
             items_sent, random_items, settings_used, writes_done);
    $display("checked %0d samples, %0d of them flagged as end of run",
             results_seen, lasts_seen);
    if (fails == 0 && expected_samples.size() == 0) begin
      $display("PASS multi_tone_sine_generator");
    end else begin
      $display("FAIL multi_tone_sine_generator");
    end
    $finish;
  end

endmodule
